// ----- hw/rtl/ores_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ores_pkg
// Shared types and constants of the 1-Wire search ROM engine.
// ----------------------------------------------------------------------------
package ores_pkg;

    localparam int ROM_BITS_DEF = 64;
    localparam int ROM_CODE_W   = 64;

    // Echo byte of the reset slot when no device pulled the bus low
    localparam logic [7:0] RESET_BYTE = 8'hF0;

    typedef enum logic [2:0] {
        ST_PASS_STARTED  = 3'd0,
        ST_NO_PRESENCE   = 3'd1,
        ST_SEARCH_DONE   = 3'd2,
        ST_BIT_DECIDED   = 3'd3,
        ST_NO_RESPONDER  = 3'd4,
        ST_NOT_IN_PASS   = 3'd5
    } status_t;

    typedef enum logic {
        MODE_START = 1'b0,
        MODE_BIT   = 1'b1
    } mode_t;

    typedef struct packed {
        status_t                 status;
        logic                    write_bit;
        logic                    rom_ready;
        logic [ROM_CODE_W-1:0]   rom_code;
        logic                    more_devices;
    } result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ores_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ores_in_if
// Input channel: start items and bit pair items.
// ----------------------------------------------------------------------------
interface ores_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] reset_echo;
    logic       id_bit;
    logic       complement_bit;

    modport source (
        output valid, mode, reset_echo, id_bit, complement_bit,
        input  ready
    );

    modport sink (
        input  valid, mode, reset_echo, id_bit, complement_bit,
        output ready
    );
endinterface
`default_nettype wire

// ----- hw/rtl/ores_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ores_out_if
// Result channel: status, direction bit and found ROM code.
// ----------------------------------------------------------------------------
interface ores_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        write_bit;
    logic        rom_ready;
    logic [63:0] rom_code;
    logic        more_devices;

    modport source (
        output valid, status, write_bit, rom_ready, rom_code, more_devices,
        input  ready
    );

    modport sink (
        input  valid, status, write_bit, rom_ready, rom_code, more_devices,
        output ready
    );
endinterface
`default_nettype wire

// ----- hw/rtl/ores_decide.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ores_decide
// Decision logic of one item: next search state and the result item.
// ----------------------------------------------------------------------------
module ores_decide
    import ores_pkg::*;
#(
    parameter int ROM_BITS = ROM_BITS_DEF,
    localparam int PW = $clog2(ROM_BITS + 1),
    localparam int IW = $clog2(ROM_BITS)
)
(
    input  wire logic                mode,
    input  wire logic [7:0]          reset_echo,
    input  wire logic                id_bit,
    input  wire logic                complement_bit,

    input  wire logic [PW-1:0]       last_branch,
    input  wire logic [PW-1:0]       pass_branch,
    input  wire logic [PW-1:0]       bit_position,
    input  wire logic [ROM_BITS-1:0] rom_bits,
    input  wire logic                pass_active,
    input  wire logic                search_done,

    output logic      [PW-1:0]       last_branch_next,
    output logic      [PW-1:0]       pass_branch_next,
    output logic      [PW-1:0]       bit_position_next,
    output logic      [ROM_BITS-1:0] rom_bits_next,
    output logic                     pass_active_next,
    output logic                     search_done_next,
    output result_t                  res
);

    logic [PW-1:0] pos;
    logic [IW-1:0] idx;
    logic          dir;

    assign pos = PW'(bit_position + PW'(1));
    assign idx = bit_position[IW-1:0];

    always_comb
    begin
        last_branch_next  = last_branch;
        pass_branch_next  = pass_branch;
        bit_position_next = bit_position;
        rom_bits_next     = rom_bits;
        pass_active_next  = pass_active;
        search_done_next  = search_done;
        dir               = 1'b0;

        res.status       = ST_NOT_IN_PASS;
        res.write_bit    = 1'b0;
        res.rom_ready    = 1'b0;
        res.rom_code     = '0;
        res.more_devices = 1'b0;

        if (mode == MODE_START)
        begin
            pass_active_next = 1'b0;
            if (search_done)
            begin
                // last device was found: start over on the next start item
                search_done_next = 1'b0;
                last_branch_next = '0;
                res.status       = ST_SEARCH_DONE;
            end
            else if (reset_echo == RESET_BYTE)
            begin
                last_branch_next = '0;
                res.status       = ST_NO_PRESENCE;
            end
            else
            begin
                pass_active_next  = 1'b1;
                bit_position_next = '0;
                pass_branch_next  = '0;
                res.status        = ST_PASS_STARTED;
            end
        end
        else if (!pass_active || (bit_position >= PW'(ROM_BITS)))
        begin
            pass_active_next = 1'b0;
            res.status       = ST_NOT_IN_PASS;
        end
        else if (id_bit && complement_bit)
        begin
            pass_active_next = 1'b0;
            last_branch_next = '0;
            search_done_next = 1'b0;
            res.status       = ST_NO_RESPONDER;
        end
        else
        begin
            priority if (id_bit != complement_bit)
            begin
                dir = id_bit;
            end
            else if (pos == last_branch)
            begin
                dir = 1'b1;
            end
            else if (pos > last_branch)
            begin
                dir              = 1'b0;
                pass_branch_next = pos;
            end
            else
            begin
                // below the last discrepancy: follow the previous code
                dir = rom_bits[idx];
                if (!dir)
                begin
                    pass_branch_next = pos;
                end
            end

            rom_bits_next[idx] = dir;
            bit_position_next  = pos;
            res.status         = ST_BIT_DECIDED;
            res.write_bit      = dir;

            if (pos >= PW'(ROM_BITS))
            begin
                last_branch_next = pass_branch_next;
                search_done_next = (pass_branch_next == '0);
                pass_active_next = 1'b0;
                res.rom_ready    = 1'b1;
                res.rom_code     = ROM_CODE_W'(rom_bits_next);
                res.more_devices = (pass_branch_next != '0);
            end
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/onewire_rom_search_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// onewire_rom_search_engine
// Search ROM decision engine for a 1-Wire master.
// ----------------------------------------------------------------------------
// The engine takes one item per clock cycle while the result is not stalled.
// An accepted item is held in an input register, then a single decision
// stage updates the search state (last discrepancy, current code, bit
// position) and loads the result register, so items can follow back to
// back. The sustained rate of one item per cycle is set by that decision
// stage, whose next state feeds the following item. A stalled result holds
// the result register and the search state; an empty input register still
// takes one more item. Send a start item with the reset slot echo, then one
// bit item per bit pair; after the last bit the result carries the ROM code
// and whether another pass will find another device.
module onewire_rom_search_engine
    import ores_pkg::*;
#(
    parameter int ROM_BITS = ROM_BITS_DEF,
    localparam int PW = $clog2(ROM_BITS + 1)
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ores_in_if.sink    item,
    ores_out_if.source resp
);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic       mode_reg;
    logic [7:0] reset_echo_reg;
    logic       id_bit_reg;
    logic       complement_bit_reg;

    // search state
    logic [PW-1:0]       last_branch_reg, last_branch_next;
    logic [PW-1:0]       pass_branch_reg, pass_branch_next;
    logic [PW-1:0]       bit_position_reg, bit_position_next;
    logic [ROM_BITS-1:0] rom_bits_reg, rom_bits_next;
    logic                pass_active_reg, pass_active_next;
    logic                search_done_reg, search_done_next;

    // result register
    logic    out_valid_reg, out_valid_next;
    result_t res_reg;
    result_t res_comb;

    logic in_xfer;
    logic advance;

    assign advance    = in_valid_reg && (!out_valid_reg || resp.ready);
    assign item.ready = !in_valid_reg || advance;
    assign in_xfer    = item.valid && item.ready;

    ores_decide #(
        .ROM_BITS (ROM_BITS)
    ) u_decide (
        .mode              (mode_reg),
        .reset_echo        (reset_echo_reg),
        .id_bit            (id_bit_reg),
        .complement_bit    (complement_bit_reg),
        .last_branch       (last_branch_reg),
        .pass_branch       (pass_branch_reg),
        .bit_position      (bit_position_reg),
        .rom_bits          (rom_bits_reg),
        .pass_active       (pass_active_reg),
        .search_done       (search_done_reg),
        .last_branch_next  (last_branch_next),
        .pass_branch_next  (pass_branch_next),
        .bit_position_next (bit_position_next),
        .rom_bits_next     (rom_bits_next),
        .pass_active_next  (pass_active_next),
        .search_done_next  (search_done_next),
        .res               (res_comb)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (resp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            last_branch_reg  <= '0;
            pass_branch_reg  <= '0;
            bit_position_reg <= '0;
            rom_bits_reg     <= '0;
            pass_active_reg  <= 1'b0;
            search_done_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                last_branch_reg  <= last_branch_next;
                pass_branch_reg  <= pass_branch_next;
                bit_position_reg <= bit_position_next;
                rom_bits_reg     <= rom_bits_next;
                pass_active_reg  <= pass_active_next;
                search_done_reg  <= search_done_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mode_reg           <= item.mode;
            reset_echo_reg     <= item.reset_echo;
            id_bit_reg         <= item.id_bit;
            complement_bit_reg <= item.complement_bit;
        end
        if (advance)
        begin
            res_reg <= res_comb;
        end
    end

    assign resp.valid        = out_valid_reg;
    assign resp.status       = res_reg.status;
    assign resp.write_bit    = res_reg.write_bit;
    assign resp.rom_ready    = res_reg.rom_ready;
    assign resp.rom_code     = res_reg.rom_code;
    assign resp.more_devices = res_reg.more_devices;

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pass_active_reg |-> (bit_position_reg < PW'(ROM_BITS)))
        else $error("bit position past the code length during a pass");

    a_done_clears_branch: assert property (@(posedge clk) disable iff (!rst_n)
        search_done_reg |-> (last_branch_reg == '0))
        else $error("search finished with a pending discrepancy");

    a_code_ends_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_comb.rom_ready) |=> (!pass_active_reg && out_valid_reg))
        else $error("completed code did not end the pass");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(mode_reg)))
        else $error("stalled input item dropped");

endmodule
`default_nettype wire
